// File: src/drs_pkg.sv
package drs_pkg;

   // Fixed point of the spin rate: 1.0 in 8.24
   localparam int unsigned FRAC_BITS  = 24;
   localparam int unsigned RATE_W     = 31;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned FAST_W     = 29;
   localparam int unsigned MULT_T_W   = 17;

   localparam logic [WORD_W-1:0] UNITY      = 32'd16777216;
   localparam logic [WORD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] FAST_LIMIT = 32'd134217728;   // eight times unity
   localparam logic [WORD_W-1:0] NATIVE_RST = 32'd16777216;

   // Shared divider: widest dividend is rate << 24
   localparam int unsigned DVD_W      = RATE_W + FRAC_BITS;
   localparam int unsigned CNT_W      = 6;
   localparam logic [CNT_W-1:0] STEPS_SPIN = 6'(DVD_W);
   localparam logic [CNT_W-1:0] STEPS_WORD = 6'(WORD_W);

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [WORD_W-1:0] divisor;
      logic [CNT_W-1:0]  steps;
   } div_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
   } div_sts_type;

endpackage

// File: src/drs_div.sv
// Restoring divider, one quotient bit per cycle. The dividend is taken MSB
// first; only the low 32 quotient bits are kept. A zero divisor yields all ones.
module drs_div
   import drs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_sts_type  sts
);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = shifted >= {1'b0, dsr_ff};

      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctrl.start) begin
         dvd_in  = ctrl.dividend;
         dsr_in  = ctrl.divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = ctrl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], ge};
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

// File: src/delay_resample_rate_setup_top.sv
// Resampling setup for a variable-speed delay line. Each request is either a
// clear (req_kind = 1), which drops the resampling flag, or a setup for a
// render rate. A setup with the flag clear and req_rate equal to the native
// rate returns an all-zero, inactive response; any other setup sets the flag
// and returns the 8.24 spin rate, its reciprocal and the slow- or fast-mode
// settings. One request is in flight at a time. Clear and native-rate requests
// go straight from IDLE to DONE; setups wait on the single shared bit-serial
// divider: 55 steps for the spin rate, 32 for the reciprocal and, in slow mode,
// 32 for the write-size adjustment. A finished response sits in an output
// register, so the next request transfers while it waits for rsp_ready.
// csr_native_rate is always taken and must be written only while idle.
module delay_resample_rate_setup_top
   import drs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WORD_W-1:0] csr_native_rate,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [RATE_W-1:0] req_rate,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_active,
   output logic              rsp_slow_mode,
   output logic [WORD_W-1:0] rsp_spin_rate,
   output logic [FAST_W-1:0] rsp_fast_spin_rate,
   output logic [WORD_W-1:0] rsp_reciprocal_rate,
   output logic [WORD_W-1:0] rsp_rate_multiple,
   output logic [WORD_W-1:0] rsp_write_size_adjust
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SPIN   = 7'b0000010,
      ST_RECIP  = 7'b0000100,
      ST_MUL    = 7'b0001000,
      ST_WSA_GO = 7'b0010000,
      ST_WSA    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic              flag_ff, flag_in;
   logic [WORD_W-1:0] native_ff, native_in;

   // Working values of the request in flight
   logic              act_ff, act_in;
   logic              slow_ff, slow_in;
   logic [WORD_W-1:0] spin_ff, spin_in;
   logic [WORD_W-1:0] recip_ff, recip_in;
   logic [WORD_W-1:0] mult_ff, mult_in;
   logic [WORD_W-1:0] wsa_ff, wsa_in;

   // Output register
   logic              ovld_ff, ovld_in;
   logic              oact_ff, oact_in;
   logic              oslow_ff, oslow_in;
   logic [WORD_W-1:0] ospin_ff, ospin_in;
   logic [FAST_W-1:0] ofast_ff, ofast_in;
   logic [WORD_W-1:0] orecip_ff, orecip_in;
   logic [WORD_W-1:0] omult_ff, omult_in;
   logic [WORD_W-1:0] owsa_ff, owsa_in;

   div_ctrl_type      div_ctrl;
   div_sts_type       div_sts;

   logic                req_xfer;
   logic                out_free;
   logic [MULT_T_W-1:0] t1;
   logic [40:0]         prod_mult;
   logic [48:0]         prod_wsa;
   logic [WORD_W-1:0]   clamped;

   drs_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .sts   (div_sts)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !ovld_ff || rsp_ready;

   // t = (reciprocal >> 16) + 1, at most 0x10000
   assign t1        = {1'b0, recip_ff[WORD_W-1:16]} + MULT_T_W'(1);
   assign prod_mult = spin_ff[WORD_W-1:8] * t1;
   assign prod_wsa  = mult_ff * t1;
   assign clamped   = (spin_ff < FAST_LIMIT) ? spin_ff : FAST_LIMIT;

   always_comb begin
      state_in  = state_ff;
      flag_in   = flag_ff;
      native_in = native_ff;
      act_in    = act_ff;
      slow_in   = slow_ff;
      spin_in   = spin_ff;
      recip_in  = recip_ff;
      mult_in   = mult_ff;
      wsa_in    = wsa_ff;

      ovld_in   = ovld_ff;
      oact_in   = oact_ff;
      oslow_in  = oslow_ff;
      ospin_in  = ospin_ff;
      ofast_in  = ofast_ff;
      orecip_in = orecip_ff;
      omult_in  = omult_ff;
      owsa_in   = owsa_ff;

      div_ctrl          = '0;
      div_ctrl.dividend = {req_rate, FRAC_BITS'(0)};
      div_ctrl.divisor  = native_ff;
      div_ctrl.steps    = STEPS_SPIN;

      if (csr_valid && csr_ready) begin
         native_in = csr_native_rate;
      end

      // Drop the response once it is taken
      if (ovld_ff && rsp_ready) begin
         ovld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_kind) begin
                  flag_in  = 1'b0;
                  act_in   = 1'b0;
                  state_in = ST_DONE;
               end else if (!flag_ff && ({1'b0, req_rate} == native_ff)) begin
                  act_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  flag_in        = 1'b1;
                  act_in         = 1'b1;
                  div_ctrl.start = 1'b1;
                  state_in       = ST_SPIN;
               end
            end
         end
         ST_SPIN: begin
            if (div_sts.done) begin
               spin_in           = div_sts.quotient;
               div_ctrl.start    = 1'b1;
               div_ctrl.dividend = {ALL_ONES, (DVD_W - WORD_W)'(0)};
               div_ctrl.divisor  = {8'd0, div_sts.quotient[WORD_W-1:8]};
               div_ctrl.steps    = STEPS_WORD;
               state_in          = ST_RECIP;
            end
         end
         ST_RECIP: begin
            if (div_sts.done) begin
               recip_in = div_sts.quotient;
               slow_in  = spin_ff < UNITY;
               state_in = (spin_ff < UNITY) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            mult_in  = prod_mult[WORD_W-1:0];
            state_in = ST_WSA_GO;
         end
         ST_WSA_GO: begin
            div_ctrl.start    = 1'b1;
            div_ctrl.dividend = {ALL_ONES, (DVD_W - WORD_W)'(0)};
            div_ctrl.divisor  = prod_wsa[WORD_W-1:0];
            div_ctrl.steps    = STEPS_WORD;
            state_in          = ST_WSA;
         end
         ST_WSA: begin
            if (div_sts.done) begin
               wsa_in   = div_sts.quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free, then load it
            if (out_free) begin
               ovld_in   = 1'b1;
               oact_in   = act_ff;
               oslow_in  = act_ff && slow_ff;
               ospin_in  = act_ff ? spin_ff : '0;
               ofast_in  = (act_ff && !slow_ff) ? {clamped[FAST_W-2:0], 1'b0} : '0;
               orecip_in = !act_ff ? '0 : (slow_ff ? recip_ff : {1'b0, recip_ff[WORD_W-1:1]});
               omult_in  = (act_ff && slow_ff) ? mult_ff : '0;
               owsa_in   = (act_ff && slow_ff) ? wsa_ff : '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         flag_ff   <= 1'b0;
         native_ff <= NATIVE_RST;
         ovld_ff   <= 1'b0;
         act_ff    <= 1'b0;
         slow_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         flag_ff   <= flag_in;
         native_ff <= native_in;
         ovld_ff   <= ovld_in;
         act_ff    <= act_in;
         slow_ff   <= slow_in;
      end
   end

   always_ff @(posedge clock) begin
      spin_ff   <= spin_in;
      recip_ff  <= recip_in;
      mult_ff   <= mult_in;
      wsa_ff    <= wsa_in;
      oact_ff   <= oact_in;
      oslow_ff  <= oslow_in;
      ospin_ff  <= ospin_in;
      ofast_ff  <= ofast_in;
      orecip_ff <= orecip_in;
      omult_ff  <= omult_in;
      owsa_ff   <= owsa_in;
   end

   assign rsp_valid             = ovld_ff;
   assign rsp_active            = oact_ff;
   assign rsp_slow_mode         = oslow_ff;
   assign rsp_spin_rate         = ospin_ff;
   assign rsp_fast_spin_rate    = ofast_ff;
   assign rsp_reciprocal_rate   = orecip_ff;
   assign rsp_rate_multiple     = omult_ff;
   assign rsp_write_size_adjust = owsa_ff;

   a_clear_drops_flag: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind |=> !flag_ff)
      else $error("flag still set after clear transfer");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_SPIN || state_ff == ST_RECIP || state_ff == ST_WSA))
      else $error("divider finished outside a divide step");

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> (rsp_spin_rate == '0 && !rsp_slow_mode
                                    && rsp_reciprocal_rate == '0))
      else $error("inactive response carries settings");

   a_mode_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slow_mode |-> rsp_fast_spin_rate == '0)
      else $error("slow-mode response has a fast spin rate");

endmodule

// File: tb/resample_setup_checker.sv
module resample_setup_checker
   import drs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [WORD_W-1:0] csr_native_rate,

   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_kind,
   input  logic [RATE_W-1:0] req_rate,

   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_active,
   input  logic              rsp_slow_mode,
   input  logic [WORD_W-1:0] rsp_spin_rate,
   input  logic [FAST_W-1:0] rsp_fast_spin_rate,
   input  logic [WORD_W-1:0] rsp_reciprocal_rate,
   input  logic [WORD_W-1:0] rsp_rate_multiple,
   input  logic [WORD_W-1:0] rsp_write_size_adjust,

   output int                fault_count,
   output int                open_count
);

   typedef struct packed {
      logic              active;
      logic              slow_mode;
      logic [WORD_W-1:0] spin_rate;
      logic [FAST_W-1:0] fast_spin_rate;
      logic [WORD_W-1:0] reciprocal_rate;
      logic [WORD_W-1:0] rate_multiple;
      logic [WORD_W-1:0] write_size_adjust;
   } rate_settings_type;

   rate_settings_type settings_due[$];
   logic [WORD_W-1:0] native_copy;
   logic              resample_flag;
   int                reported;

   function automatic logic [WORD_W-1:0] quot_sat(input logic [WORD_W-1:0] num,
                                                  input logic [WORD_W-1:0] den);
      return (den == '0) ? ALL_ONES : num / den;
   endfunction

   // Full settings for an active setup at the given rate
   function automatic rate_settings_type derive_settings(input logic [RATE_W-1:0] rate,
                                                         input logic [WORD_W-1:0] native);
      logic [63:0]       scaled;
      logic [WORD_W-1:0] spin;
      logic [WORD_W-1:0] step;
      logic [WORD_W-1:0] recip;
      logic [WORD_W-1:0] t1;
      logic [WORD_W-1:0] mult;
      logic [WORD_W-1:0] clamped;
      rate_settings_type s;
      s = '0;
      scaled = {33'd0, rate} << FRAC_BITS;
      spin = (native == '0) ? ALL_ONES : WORD_W'(scaled / {32'd0, native});
      step = spin >> 8;
      recip = quot_sat(ALL_ONES, step);
      s.active = 1'b1;
      s.spin_rate = spin;
      if (spin < UNITY) begin
         t1 = (recip >> 16) + 32'd1;
         mult = step * t1;
         s.slow_mode = 1'b1;
         s.reciprocal_rate = recip;
         s.rate_multiple = mult;
         s.write_size_adjust = quot_sat(ALL_ONES, mult * t1);
      end else begin
         clamped = (spin < FAST_LIMIT) ? spin : FAST_LIMIT;
         s.fast_spin_rate = FAST_W'(clamped << 1);
         s.reciprocal_rate = recip >> 1;
      end
      return s;
   endfunction

   task automatic note_fault(input string what, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
      fault_count++;
      if (reported < 10) begin
         reported++;
         $display("mismatch %s: expected %h, got %h", what, want, got);
      end
   endtask

   always @(posedge clock) begin
      rate_settings_type want;
      logic              next_flag;
      if (reset) begin
         settings_due.delete();
         native_copy = NATIVE_RST;
         resample_flag = 1'b0;
         fault_count = 0;
         reported = 0;
      end else begin
         if (csr_valid && csr_ready)
            native_copy = csr_native_rate;

         // retire the oldest expectation first: it can never be this cycle's request
         if (rsp_valid && rsp_ready) begin
            if (settings_due.size() == 0) begin
               note_fault("response with nothing pending", '0, '0);
            end else begin
               want = settings_due.pop_front();
               if (rsp_active != want.active)
                  note_fault("active", 32'(want.active), 32'(rsp_active));
               if (rsp_slow_mode != want.slow_mode)
                  note_fault("slow_mode", 32'(want.slow_mode), 32'(rsp_slow_mode));
               if (rsp_spin_rate != want.spin_rate)
                  note_fault("spin_rate", want.spin_rate, rsp_spin_rate);
               if (rsp_fast_spin_rate != want.fast_spin_rate)
                  note_fault("fast_spin_rate", 32'(want.fast_spin_rate),
                             32'(rsp_fast_spin_rate));
               if (rsp_reciprocal_rate != want.reciprocal_rate)
                  note_fault("reciprocal_rate", want.reciprocal_rate, rsp_reciprocal_rate);
               if (rsp_rate_multiple != want.rate_multiple)
                  note_fault("rate_multiple", want.rate_multiple, rsp_rate_multiple);
               if (rsp_write_size_adjust != want.write_size_adjust)
                  note_fault("write_size_adjust", want.write_size_adjust,
                             rsp_write_size_adjust);
            end
         end

         if (req_valid && req_ready) begin
            // active exactly when the flag ends up set
            next_flag = !req_kind && (resample_flag || ({1'b0, req_rate} != native_copy));
            resample_flag = next_flag;
            settings_due.push_back(next_flag ? derive_settings(req_rate, native_copy) : '0);
         end
      end
      open_count = settings_due.size();
   end

endmodule

// File: tb/tb.sv
module tb;
   import drs_pkg::*;

   // Generous bound on the whole run, counted from time zero: every item and gap, many times over
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int HOLD_CYCLES = 500;
   localparam int PHASE_ITEMS = 103;
   localparam logic [RATE_W-1:0] RATE_MAX = '1;

   logic              clock;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [WORD_W-1:0] csr_native_rate;
   logic              req_valid;
   logic              req_ready;
   logic              req_kind;
   logic [RATE_W-1:0] req_rate;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_active;
   logic              rsp_slow_mode;
   logic [WORD_W-1:0] rsp_spin_rate;
   logic [FAST_W-1:0] rsp_fast_spin_rate;
   logic [WORD_W-1:0] rsp_reciprocal_rate;
   logic [WORD_W-1:0] rsp_rate_multiple;
   logic [WORD_W-1:0] rsp_write_size_adjust;

   int                fault_count;
   int                open_count;
   int                cycles;

   // Idle controls for the sender and receiver processes, and the current native rate
   logic              src_lazy;
   logic              sink_lazy;
   int                hold_asks;
   int                holds_served;
   logic [WORD_W-1:0] native_now;

   delay_resample_rate_setup_top uut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_native_rate      (csr_native_rate),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_rate             (req_rate),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_active           (rsp_active),
      .rsp_slow_mode        (rsp_slow_mode),
      .rsp_spin_rate        (rsp_spin_rate),
      .rsp_fast_spin_rate   (rsp_fast_spin_rate),
      .rsp_reciprocal_rate  (rsp_reciprocal_rate),
      .rsp_rate_multiple    (rsp_rate_multiple),
      .rsp_write_size_adjust(rsp_write_size_adjust)
   );

   resample_setup_checker settings_check (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_native_rate      (csr_native_rate),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_rate             (req_rate),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_active           (rsp_active),
      .rsp_slow_mode        (rsp_slow_mode),
      .rsp_spin_rate        (rsp_spin_rate),
      .rsp_fast_spin_rate   (rsp_fast_spin_rate),
      .rsp_reciprocal_rate  (rsp_reciprocal_rate),
      .rsp_rate_multiple    (rsp_rate_multiple),
      .rsp_write_size_adjust(rsp_write_size_adjust),
      .fault_count          (fault_count),
      .open_count           (open_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watchdog: end the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Mostly back-to-back, sometimes a few idle cycles, rarely a long pause; never idle unless lazy
   function automatic int idle_gap(input logic lazy);
      int roll;
      if (!lazy)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 4);
      else
         return $urandom_range(15, 60);
   endfunction

   // Receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin : sink_side
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_asks) begin
            // hold off so that the block fills up and stalls its input
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_served++;
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            stall_left = idle_gap(sink_lazy);
         end
      end
   end

   // Offer one request; return at the falling edge after its transfer
   task automatic offer_request(input logic kind, input logic [RATE_W-1:0] rate);
      int gap;
      gap = idle_gap(src_lazy);
      if (gap > 0) begin
         req_valid = 1'b0;
         req_kind = 1'($urandom);
         req_rate = RATE_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_kind = kind;
      req_rate = rate;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every response has come back
   task automatic drain_responses();
      req_valid = 1'b0;
      while (open_count != 0) @(negedge clock);
   endtask

   task automatic write_native(input logic [WORD_W-1:0] value);
      csr_native_rate = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      native_now = value;
   endtask

   // Random rate, biased toward the native rate, tiny values and the clamp edge
   function automatic logic [RATE_W-1:0] pick_rate(input logic [WORD_W-1:0] native);
      logic [63:0] pick;
      case ($urandom_range(0, 9))
         0: pick = {32'd0, native};
         1: pick = {32'd0, native} + 64'($urandom_range(0, 8)) - 64'd4;
         2: pick = 64'($urandom_range(0, 511));
         3: pick = 64'd1 << $urandom_range(0, 30);
         4: pick = ({32'd0, native} << 3) + 64'($urandom_range(0, 4)) - 64'd2;
         default: pick = 64'($urandom);
      endcase
      if (pick > 64'(RATE_MAX))
         pick = 64'($urandom) & 64'(RATE_MAX);
      return RATE_W'(pick);
   endfunction

   initial begin : stimulus
      logic [WORD_W-1:0] natives [10];
      int                sent;
      int                roll;

      natives = '{UNITY, 32'd1, ALL_ONES, 32'd48000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'd3, 32'd0, UNITY, 32'd0};
      natives[7] = $urandom_range(2, 32'h00FF_FFFF);
      natives[9] = $urandom() | 32'd1;

      cycles = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_native_rate = '0;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_rate = '0;
      src_lazy = 1'b0;
      sink_lazy = 1'b0;
      hold_asks = 0;
      holds_served = 0;
      native_now = NATIVE_RST;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pass at the reset native rate (unity)
      offer_request(1'b0, RATE_W'(UNITY));            // native with flag clear: inactive
      offer_request(1'b0, RATE_W'(UNITY));
      offer_request(1'b0, '0);                        // zero spin, reciprocal divisor zero
      offer_request(1'b0, RATE_W'(UNITY));            // flag set: fast mode at unity
      offer_request(1'b1, '0);                        // clear
      offer_request(1'b0, RATE_W'(UNITY));            // inactive again
      offer_request(1'b1, RATE_MAX);
      offer_request(1'b0, RATE_MAX);                  // fast, clamped
      offer_request(1'b0, RATE_W'(UNITY - 1));        // slow just below unity
      offer_request(1'b0, RATE_W'(FAST_LIMIT));       // exactly at the clamp
      offer_request(1'b0, RATE_W'(FAST_LIMIT - 1));
      offer_request(1'b0, RATE_W'(FAST_LIMIT + 1));
      offer_request(1'b0, 31'd255);                   // spin below one step
      offer_request(1'b0, 31'd256);                   // write-size product wraps to zero
      offer_request(1'b0, 31'd1);
      offer_request(1'b0, RATE_W'(UNITY + 1));
      offer_request(1'b1, RATE_MAX);
      offer_request(1'b0, 31'h4000_0000);
      offer_request(1'b0, 31'd65535);
      offer_request(1'b1, '0);
      drain_responses();

      // Random phases, one native rate each
      foreach (natives[p]) begin
         write_native(natives[p]);
         src_lazy = (p % 3 != 0);
         sink_lazy = (p % 3 != 0);
         if (p == 2 || p == 6)
            hold_asks++;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               offer_request(1'b1, RATE_W'($urandom));
               sent++;
            end else if (roll < 16) begin
               // clear, then a native-rate setup, inactive unless the native rate does not fit in 31 bits
               offer_request(1'b1, RATE_W'($urandom));
               offer_request(1'b0, RATE_W'(native_now));
               sent += 2;
            end else begin
               offer_request(1'b0, pick_rate(native_now));
               sent++;
            end
         end
         drain_responses();
      end

      repeat (20) @(posedge clock);
      if (fault_count == 0 && open_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
